FILE: rtl/rpsp_pkg.sv
// shared types, constants and helpers for the ray square pick pipeline
package rpsp_pkg;

	// coordinate format: signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS
	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 16;

	// square side register: unsigned Q8.FRAC_BITS, reset to 0.3
	localparam int SIZE_WIDTH = 24;
	localparam int SIZE_RESET_INT = ((3 << FRAC_BITS) + 5) / 10;
	localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(SIZE_RESET_INT);

	// product and compare widths
	localparam int PROD_W = 2 * COORD_WIDTH;
	localparam int LIM_W  = SIZE_WIDTH + COORD_WIDTH;
	localparam int CMP_W  = ((PROD_W + 1 > LIM_W) ? PROD_W + 1 : LIM_W) + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COORD_WIDTH-1:0] mag_t;
	typedef logic [PROD_W-1:0] uprod_t;

	typedef enum logic [1:0] {
		PLANE_XY = 2'd0,
		PLANE_XZ = 2'd1,
		PLANE_YZ = 2'd2
	} plane_t;

	// stage load enables handed to the plane units
	typedef struct packed {
		logic s2;
		logic s3;
	} adv_t;

	// magnitude of a coordinate; the most negative value maps to 2^(w-1)
	function automatic mag_t mag(input coord_t v);
		mag_t r;
		r = v[COORD_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
		return r;
	endfunction

endpackage

FILE: rtl/rpsp_plane.sv
// one square test: cross products, then bounds compare against the half side
module rpsp_plane (
	input  logic                               clk,
	input  rpsp_pkg::adv_t                     adv,
	input  rpsp_pkg::coord_t                   on,
	input  rpsp_pkg::coord_t                   dn,
	input  rpsp_pkg::coord_t                   oa,
	input  rpsp_pkg::coord_t                   da,
	input  rpsp_pkg::coord_t                   ob,
	input  rpsp_pkg::coord_t                   db,
	input  logic [rpsp_pkg::SIZE_WIDTH-1:0]    square_size,
	output logic                               ok_s3
);

	logic signed [rpsp_pkg::PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic [rpsp_pkg::LIM_W-1:0]         lim_s2;
	logic                               gate_s2;

	logic                               facing;
	logic signed [rpsp_pkg::CMP_W-1:0]  diff_a, diff_b, half;
	logic                               in_a, in_b;

	// plane is a candidate when the ray is not parallel and not pointing away
	assign facing = (dn != '0)
		&& !((!on[rpsp_pkg::COORD_WIDTH-1] && on != '0 && !dn[rpsp_pkg::COORD_WIDTH-1])
		|| (on[rpsp_pkg::COORD_WIDTH-1] && dn[rpsp_pkg::COORD_WIDTH-1]));

	// multiplier stage
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			pa_s2   <= rpsp_pkg::PROD_W'(oa) * rpsp_pkg::PROD_W'(dn);
			pb_s2   <= rpsp_pkg::PROD_W'(on) * rpsp_pkg::PROD_W'(da);
			pc_s2   <= rpsp_pkg::PROD_W'(ob) * rpsp_pkg::PROD_W'(dn);
			pd_s2   <= rpsp_pkg::PROD_W'(on) * rpsp_pkg::PROD_W'(db);
			lim_s2  <= rpsp_pkg::LIM_W'(square_size) * rpsp_pkg::LIM_W'(rpsp_pkg::mag(dn));
			gate_s2 <= facing;
		end
	end

	// |a*dn - on*da| <= (size*|dn|)/2 written as a two-sided signed compare
	always_comb begin
		diff_a = rpsp_pkg::CMP_W'(pa_s2) - rpsp_pkg::CMP_W'(pb_s2);
		diff_b = rpsp_pkg::CMP_W'(pc_s2) - rpsp_pkg::CMP_W'(pd_s2);
		half   = signed'(rpsp_pkg::CMP_W'(lim_s2 >> 1));
		in_a   = (diff_a <= half) && (diff_a >= -half);
		in_b   = (diff_b <= half) && (diff_b >= -half);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			ok_s3 <= gate_s2 && in_a && in_b;
		end
	end

endmodule

FILE: rtl/ray_plane_square_pick.sv
// Ray pick against three origin-centred squares in the XY, XZ and YZ planes.
// The block is a four-stage pipeline: input register, multiplier stage
// (cross products, side limits and distance cross products), compare stage,
// and nearest-plane select into the output register. One ray is accepted
// every cycle while out_ready does not stall the pipeline; the result passes
// the input, multiplier, compare and output registers in turn before
// out_valid rises, and is held back further only while out_ready is low.
// Empty stages absorb stalls, so in_ready follows out_ready combinationally
// only through a full pipeline. square_size may be written only while no
// transaction is in flight.
module ray_plane_square_pick (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            square_size_we,
	input  logic [rpsp_pkg::SIZE_WIDTH-1:0] square_size,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rpsp_pkg::coord_t                origin_x,
	input  rpsp_pkg::coord_t                origin_y,
	input  rpsp_pkg::coord_t                origin_z,
	input  rpsp_pkg::coord_t                dir_x,
	input  rpsp_pkg::coord_t                dir_y,
	input  rpsp_pkg::coord_t                dir_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [1:0]                      plane_code
);

	logic [rpsp_pkg::SIZE_WIDTH-1:0] size_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	rpsp_pkg::adv_t adv;

	rpsp_pkg::coord_t ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;
	rpsp_pkg::uprod_t q10a_s2, q10b_s2, q20a_s2, q20b_s2, q21a_s2, q21b_s2;
	logic lt10_s3, lt20_s3, lt21_s3;
	logic ok_xy_s3, ok_xz_s3, ok_yz_s3;
	logic hit_s4;
	rpsp_pkg::plane_t code_s4;

	logic sel_found;
	rpsp_pkg::plane_t sel_code, sel_mid;
	logic sel_mid_found, sel_two_wins;

	// square side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= rpsp_pkg::SIZE_RESET;
		end else if (square_size_we) begin
			size_q <= square_size;
		end
	end

	// a stage loads when it is empty or its contents move on
	assign ld_s4    = !v_s4 || out_ready;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;
	assign adv.s2   = ld_s2;
	assign adv.s3   = ld_s3;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			ox_s1 <= origin_x;
			oy_s1 <= origin_y;
			oz_s1 <= origin_z;
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
			dz_s1 <= dir_z;
		end
	end

	// per-plane bounds tests
	rpsp_plane u_xy (
		.clk(clk), .adv(adv),
		.on(oz_s1), .dn(dz_s1), .oa(ox_s1), .da(dx_s1), .ob(oy_s1), .db(dy_s1),
		.square_size(size_q), .ok_s3(ok_xy_s3)
	);

	rpsp_plane u_xz (
		.clk(clk), .adv(adv),
		.on(oy_s1), .dn(dy_s1), .oa(ox_s1), .da(dx_s1), .ob(oz_s1), .db(dz_s1),
		.square_size(size_q), .ok_s3(ok_xz_s3)
	);

	rpsp_plane u_yz (
		.clk(clk), .adv(adv),
		.on(ox_s1), .dn(dx_s1), .oa(oy_s1), .da(dy_s1), .ob(oz_s1), .db(dz_s1),
		.square_size(size_q), .ok_s3(ok_yz_s3)
	);

	// distance cross products: t_i = |on_i| / |dn_i|
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			q10a_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(oy_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dz_s1));
			q10b_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(oz_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dy_s1));
			q20a_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(ox_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dz_s1));
			q20b_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(oz_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dx_s1));
			q21a_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(ox_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dy_s1));
			q21b_s2 <= rpsp_pkg::uprod_t'(rpsp_pkg::mag(oy_s1))
				* rpsp_pkg::uprod_t'(rpsp_pkg::mag(dx_s1));
		end
	end

	// strictly nearer tests between plane pairs
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			lt10_s3 <= q10a_s2 < q10b_s2;
			lt20_s3 <= q20a_s2 < q20b_s2;
			lt21_s3 <= q21a_s2 < q21b_s2;
		end
	end

	// nearest hit, earlier plane wins on a tie
	always_comb begin
		sel_mid_found = ok_xy_s3;
		sel_mid       = rpsp_pkg::PLANE_XY;
		if (ok_xz_s3 && (!ok_xy_s3 || lt10_s3)) begin
			sel_mid_found = 1'b1;
			sel_mid       = rpsp_pkg::PLANE_XZ;
		end
		sel_two_wins = ok_yz_s3 && (!sel_mid_found
			|| ((sel_mid == rpsp_pkg::PLANE_XY) ? lt20_s3 : lt21_s3));
		sel_found = sel_mid_found || sel_two_wins;
		sel_code  = sel_two_wins ? rpsp_pkg::PLANE_YZ : sel_mid;
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_s4) begin
			hit_s4  <= sel_found;
			code_s4 <= sel_code;
		end
	end

	assign out_valid  = v_s4;
	assign hit        = hit_s4;
	assign plane_code = code_s4;

endmodule

FILE: rtl/rpsp_check.sv
// port-level checker for the ray square pick block, bound to the top level
module rpsp_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            square_size_we,
	input logic [rpsp_pkg::SIZE_WIDTH-1:0] square_size,
	input logic                            in_valid,
	input logic                            in_ready,
	input rpsp_pkg::coord_t                origin_x,
	input rpsp_pkg::coord_t                origin_y,
	input rpsp_pkg::coord_t                origin_z,
	input rpsp_pkg::coord_t                dir_x,
	input rpsp_pkg::coord_t                dir_y,
	input rpsp_pkg::coord_t                dir_z,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            hit,
	input logic [1:0]                      plane_code
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(plane_code))
		else $error("result changed while stalled");

	// a miss always reports the first plane code
	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> plane_code == rpsp_pkg::PLANE_XY)
		else $error("miss with nonzero plane code");

	// with no result pending the pipeline can always take a transaction
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an accepted transaction has a result showing once it has passed the input, multiplier, compare and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##4 out_valid)
		else $error("no result after pipeline latency");

endmodule

bind ray_plane_square_pick rpsp_check u_rpsp_check (.*);
